// File: design/m7_pkg.sv
// Shared types, constants and tables for the Mode-7 scanline parameter block.
// No dependencies; every other design file except m7_ifs imports this package.
`default_nettype none

package m7_pkg;

	localparam int HORIZON_LINE_DEF = 32;
	localparam int LAST_LINE        = 159;
	localparam int FOG_END_LINE     = 16 * 6;
	localparam int FOG_MAX          = 16;
	localparam int HALF_WIDTH       = 120;
	localparam int VIEW_DIST        = 128;
	localparam int SCALE_SHIFT      = 12;

	localparam int RECIP_W = 17;   // 65536 / divisor, divisor >= 1
	localparam int LAM_W   = 18;   // ground scale after the >> 12
	localparam int ROT_W   = 20;   // rotated scale, signed
	localparam int TRIG_W  = 10;   // Q8 sine, -256..256
	localparam int ORG_W   = 25;   // origin arithmetic before truncation
	localparam int STEP_W  = 15;
	localparam int OUT_ORG_W = 23;

	typedef enum logic [1:0] {
		CFG_CAMERA_X      = 2'd0,
		CFG_CAMERA_Y      = 2'd1,
		CFG_CAMERA_HEIGHT = 2'd2,
		CFG_HEADING       = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		BG_KEEP = 2'd0,
		BG_OFF  = 2'd1,
		BG_ON   = 2'd2
	} bg_action_t;

	// Per-line control that travels beside the arithmetic
	typedef struct packed {
		logic       in_display;
		bg_action_t bg_action;
		logic       fog_on;
		logic [4:0] fog_level;
		logic       affine_valid;
	} ctl_t;

	localparam logic [8:0] QUARTER_SINE [65] = '{
		9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,
		9'd49,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
		9'd97,  9'd103, 9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136,
		9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd171, 9'd176,
		9'd181, 9'd185, 9'd189, 9'd193, 9'd197, 9'd201, 9'd205, 9'd209,
		9'd212, 9'd216, 9'd219, 9'd222, 9'd225, 9'd228, 9'd231, 9'd234,
		9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246, 9'd248, 9'd249,
		9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255,
		9'd256
	};

	function automatic logic signed [TRIG_W-1:0] sine_q8(input logic [7:0] angle);
		logic [5:0] k;
		logic [6:0] idx;
		logic [8:0] mag;
		k   = angle[5:0];
		idx = angle[6] ? (7'd64 - {1'b0, k}) : {1'b0, k};
		mag = QUARTER_SINE[idx];
		return angle[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	// floor(v / 6) for 8-bit v: reciprocal multiply, exact over the full range
	function automatic logic [5:0] div6(input logic [7:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd171;
		return p[15:10];
	endfunction

endpackage

`default_nettype wire

// File: design/m7_ifs.sv
// Handshake channel interfaces: line request, line result, config write.
// Plain valid/ready channels; no package dependency.
`default_nettype none

interface m7_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] vcount;
	modport source (output valid, vcount, input ready);
	modport sink   (input valid, vcount, output ready);
endinterface

interface m7_res_if;
	logic               valid;
	logic               ready;
	logic               in_display;
	logic [1:0]         bg_action;
	logic               fog_on;
	logic [4:0]         fog_level;
	logic               affine_valid;
	logic signed [14:0] step_a;
	logic signed [14:0] step_c;
	logic signed [22:0] origin_x;
	logic signed [22:0] origin_y;
	modport source (output valid, in_display, bg_action, fog_on, fog_level, affine_valid,
		step_a, step_c, origin_x, origin_y, input ready);
	modport sink   (input valid, in_display, bg_action, fog_on, fog_level, affine_valid,
		step_a, step_c, origin_x, origin_y, output ready);
endinterface

interface m7_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/mode7_scanline_affine_params.sv
// Mode-7 scanline parameter engine. One vcount word in, one result word out per
// line; a new line is taken every clock cycle unless the output stalls. Each
// line goes through line decode with reciprocal and sine table lookup, height
// times reciprocal multiply, yaw rotation multiplies, then the origin adders
// feeding the output register. Backpressure stalls each stage only as far as
// needed, so bubbles fill up while the output waits. Config writes are taken
// every cycle and should only be issued while no line is in flight.
// Depends on m7_pkg, m7_ifs, m7_front, m7_scale, m7_origin.
`default_nettype none

module mode7_scanline_affine_params import m7_pkg::*; #(
	parameter int HORIZON_LINE = HORIZON_LINE_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	m7_cfg_if.sink    cfg,
	m7_req_if.sink    line_req,
	m7_res_if.source  line_res
);

	logic [15:0] camera_x_q;
	logic [15:0] camera_y_q;
	logic [13:0] camera_height_q;
	logic [7:0]  heading_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_x_q      <= '0;
			camera_y_q      <= '0;
			camera_height_q <= 14'd2048;
			heading_q       <= '0;
		end else if (cfg.valid) begin
			case (cfg_index_t'(cfg.index))
				CFG_CAMERA_X:      camera_x_q      <= cfg.data;
				CFG_CAMERA_Y:      camera_y_q      <= cfg.data;
				CFG_CAMERA_HEIGHT: camera_height_q <= cfg.data[13:0];
				CFG_HEADING:       heading_q       <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	logic                       valid_s1, ready_s1;
	ctl_t                       ctl_s1;
	logic [RECIP_W-1:0]         recip_s1;
	logic signed [TRIG_W-1:0]   sin_s1, cos_s1;

	logic                       valid_s3, ready_s3;
	ctl_t                       ctl_s3;
	logic signed [ROT_W-1:0]    lcf_s3, lsf_s3;

	logic                       valid_s4;
	ctl_t                       ctl_s4;

	m7_front #(.HORIZON_LINE(HORIZON_LINE)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (line_req.valid),
		.in_ready   (line_req.ready),
		.vcount     (line_req.vcount),
		.heading    (heading_q),
		.valid_s1   (valid_s1),
		.ready_next (ready_s1),
		.ctl_s1     (ctl_s1),
		.recip_s1   (recip_s1),
		.sin_s1     (sin_s1),
		.cos_s1     (cos_s1)
	);

	m7_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.ready_s1      (ready_s1),
		.ctl_s1        (ctl_s1),
		.recip_s1      (recip_s1),
		.sin_s1        (sin_s1),
		.cos_s1        (cos_s1),
		.camera_height (camera_height_q),
		.valid_s3      (valid_s3),
		.ready_next    (ready_s3),
		.ctl_s3        (ctl_s3),
		.lcf_s3        (lcf_s3),
		.lsf_s3        (lsf_s3)
	);

	m7_origin u_origin (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s3    (valid_s3),
		.ready_s3    (ready_s3),
		.ctl_s3      (ctl_s3),
		.lcf_s3      (lcf_s3),
		.lsf_s3      (lsf_s3),
		.camera_x    (camera_x_q),
		.camera_y    (camera_y_q),
		.valid_s4    (valid_s4),
		.ready_out   (line_res.ready),
		.ctl_s4      (ctl_s4),
		.step_a_s4   (line_res.step_a),
		.step_c_s4   (line_res.step_c),
		.origin_x_s4 (line_res.origin_x),
		.origin_y_s4 (line_res.origin_y)
	);

	assign line_res.valid        = valid_s4;
	assign line_res.in_display   = ctl_s4.in_display;
	assign line_res.bg_action    = ctl_s4.bg_action;
	assign line_res.fog_on       = ctl_s4.fog_on;
	assign line_res.fog_level    = ctl_s4.fog_level;
	assign line_res.affine_valid = ctl_s4.affine_valid;

endmodule

`default_nettype wire

// File: design/m7_front.sv
// Stage 1: line decode, fog and background control, reciprocal and trig lookup.
// Depends on m7_pkg.
`default_nettype none

module m7_front import m7_pkg::*; #(
	parameter int HORIZON_LINE = HORIZON_LINE_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  vcount,
	input  wire logic [7:0]                  heading,
	output logic                             valid_s1,
	input  wire logic                        ready_next,
	output ctl_t                             ctl_s1,
	output logic [RECIP_W-1:0]               recip_s1,
	output logic signed [TRIG_W-1:0]         sin_s1,
	output logic signed [TRIG_W-1:0]         cos_s1
);

	localparam logic [7:0] HL = 8'(HORIZON_LINE);

	logic [RECIP_W-1:0] recip_tab [256];

	// divisor 0 only occurs at the horizon, where 1 is used
	for (genvar g = 0; g < 256; g++) begin : g_recip
		localparam int RV = 65536 / ((g == 0) ? 1 : g);
		assign recip_tab[g] = RV[RECIP_W-1:0];
	end

	logic [7:0] line;
	logic [7:0] divisor;
	logic [7:0] half;
	logic [5:0] sixth;
	ctl_t       ctl_d;

	always_comb begin
		line    = vcount - 8'd1;
		divisor = line - HL;
		half    = line >> 1;
		sixth   = div6(line);
		ctl_d   = '0;
		if (line <= 8'(LAST_LINE)) begin
			ctl_d.in_display = 1'b1;
			if (line < HL) begin
				ctl_d.bg_action = BG_OFF;
				ctl_d.fog_on    = 1'b1;
				ctl_d.fog_level = (half > 8'(FOG_MAX)) ? 5'(FOG_MAX) : half[4:0];
			end else begin
				ctl_d.bg_action    = (line == HL) ? BG_ON : BG_KEEP;
				ctl_d.affine_valid = 1'b1;
				if (line <= 8'(FOG_END_LINE)) begin
					ctl_d.fog_on    = 1'b1;
					ctl_d.fog_level = 5'(FOG_MAX) - sixth[4:0];
				end
			end
		end
	end

	assign in_ready = !valid_s1 || ready_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctl_s1   <= ctl_d;
			recip_s1 <= recip_tab[divisor];
			sin_s1   <= sine_q8(heading);
			cos_s1   <= sine_q8(heading + 8'd64);
		end
	end

endmodule

`default_nettype wire

// File: design/m7_scale.sv
// Stages 2 and 3: ground scale (height times reciprocal), then rotation by yaw.
// Depends on m7_pkg.
`default_nettype none

module m7_scale import m7_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_s1,
	output logic                             ready_s1,
	input  wire ctl_t                        ctl_s1,
	input  wire logic [RECIP_W-1:0]          recip_s1,
	input  wire logic signed [TRIG_W-1:0]    sin_s1,
	input  wire logic signed [TRIG_W-1:0]    cos_s1,
	input  wire logic [13:0]                 camera_height,
	output logic                             valid_s3,
	input  wire logic                        ready_next,
	output ctl_t                             ctl_s3,
	output logic signed [ROT_W-1:0]          lcf_s3,
	output logic signed [ROT_W-1:0]          lsf_s3
);

	logic                      valid_s2;
	logic                      ready_s2;
	ctl_t                      ctl_s2;
	logic [LAM_W-1:0]          lam_s2;
	logic signed [TRIG_W-1:0]  sin_s2;
	logic signed [TRIG_W-1:0]  cos_s2;

	logic [30:0]               lam_full;
	logic signed [LAM_W:0]     lam_sx;
	logic signed [28:0]        pc_full;
	logic signed [28:0]        ps_full;

	assign lam_full = 31'(camera_height) * 31'(recip_s1);
	assign lam_sx   = $signed({1'b0, lam_s2});
	assign pc_full  = lam_sx * cos_s2;
	assign ps_full  = lam_sx * sin_s2;

	assign ready_s1 = !valid_s2 || ready_s2;
	assign ready_s2 = !valid_s3 || ready_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s2 <= valid_s1;
			if (ready_s2) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			ctl_s2 <= ctl_s1;
			lam_s2 <= lam_full[SCALE_SHIFT +: LAM_W];
			sin_s2 <= sin_s1;
			cos_s2 <= cos_s1;
		end
		if (ready_s2 && valid_s2) begin
			ctl_s3 <= ctl_s2;
			// arithmetic >> 8, floor
			lcf_s3 <= pc_full[8 +: ROT_W];
			lsf_s3 <= ps_full[8 +: ROT_W];
		end
	end

endmodule

`default_nettype wire

// File: design/m7_origin.sv
// Stage 4: affine steps and reference points, output register.
// Depends on m7_pkg.
`default_nettype none

module m7_origin import m7_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_s3,
	output logic                             ready_s3,
	input  wire ctl_t                        ctl_s3,
	input  wire logic signed [ROT_W-1:0]     lcf_s3,
	input  wire logic signed [ROT_W-1:0]     lsf_s3,
	input  wire logic [15:0]                 camera_x,
	input  wire logic [15:0]                 camera_y,
	output logic                             valid_s4,
	input  wire logic                        ready_out,
	output ctl_t                             ctl_s4,
	output logic signed [STEP_W-1:0]         step_a_s4,
	output logic signed [STEP_W-1:0]         step_c_s4,
	output logic signed [OUT_ORG_W-1:0]      origin_x_s4,
	output logic signed [OUT_ORG_W-1:0]      origin_y_s4
);

	logic signed [ROT_W-5:0] pa;
	logic signed [ROT_W-5:0] pc;
	logic signed [ORG_W-1:0] pa_x;
	logic signed [ORG_W-1:0] pc_x;
	logic signed [ORG_W-1:0] lcf_x;
	logic signed [ORG_W-1:0] lsf_x;
	logic signed [ORG_W-1:0] ox;
	logic signed [ORG_W-1:0] oy;

	always_comb begin
		pa    = lcf_s3[ROT_W-1:4];
		pc    = lsf_s3[ROT_W-1:4];
		pa_x  = ORG_W'(pa);
		pc_x  = ORG_W'(pc);
		lcf_x = ORG_W'(lcf_s3);
		lsf_x = ORG_W'(lsf_s3);
		// 120*p = 128p - 8p; (128*l) >> 4 = 8l
		ox = $signed(ORG_W'(camera_x)) - ((pa_x <<< 7) - (pa_x <<< 3)) + (lsf_x <<< 3);
		oy = $signed(ORG_W'(camera_y)) - ((pc_x <<< 7) - (pc_x <<< 3)) - (lcf_x <<< 3);
	end

	assign ready_s3 = !valid_s4 || ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s3) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s3) begin
			ctl_s4 <= ctl_s3;
			if (ctl_s3.affine_valid) begin
				step_a_s4   <= pa[STEP_W-1:0];
				step_c_s4   <= pc[STEP_W-1:0];
				origin_x_s4 <= ox[OUT_ORG_W-1:0];
				origin_y_s4 <= oy[OUT_ORG_W-1:0];
			end else begin
				step_a_s4   <= '0;
				step_c_s4   <= '0;
				origin_x_s4 <= '0;
				origin_y_s4 <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/m7_chk.sv
// Port-level checks for the Mode-7 scanline block, bound to the top level.
// Depends on m7_pkg and mode7_scanline_affine_params.
`default_nettype none

module m7_chk import m7_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic        in_display,
	input wire logic [1:0]  bg_action,
	input wire logic        fog_on,
	input wire logic [4:0]  fog_level,
	input wire logic        affine_valid,
	input wire logic [14:0] step_a,
	input wire logic [14:0] step_c,
	input wire logic [22:0] origin_x,
	input wire logic [22:0] origin_y
);

	// a stalled result word holds its steps, origins and background action
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(step_a) && $stable(origin_x)
			&& $stable(origin_y) && $stable(step_c) && $stable(bg_action))
		else $error("result word changed while stalled");

	// invisible lines carry an all-zero word
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !in_display |-> bg_action == BG_KEEP && !fog_on && fog_level == 5'd0
			&& !affine_valid && step_a == '0 && step_c == '0
			&& origin_x == '0 && origin_y == '0)
		else $error("invisible line with nonzero fields");

	// sky lines switch the background off and never write affine values
	a_sky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && bg_action == BG_OFF |-> in_display && fog_on && !affine_valid
			&& step_a == '0 && origin_y == '0)
		else $error("sky line with affine data");

	a_fog_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> fog_level <= 5'd16 && (fog_on || fog_level == 5'd0)
			&& (affine_valid || bg_action != BG_ON))
		else $error("fog level or background action out of range");

endmodule

bind mode7_scanline_affine_params m7_chk u_m7_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (line_res.valid),
	.res_ready    (line_res.ready),
	.in_display   (line_res.in_display),
	.bg_action    (line_res.bg_action),
	.fog_on       (line_res.fog_on),
	.fog_level    (line_res.fog_level),
	.affine_valid (line_res.affine_valid),
	.step_a       (line_res.step_a),
	.step_c       (line_res.step_c),
	.origin_x     (line_res.origin_x),
	.origin_y     (line_res.origin_y)
);

`default_nettype wire
